// ===== design/tsk_pkg.sv =====
// ----------------------------------------------------------------------------
// tsk_pkg
// Shared types and constants for the tricycle steering kinematics block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsk_pkg;

  // Field widths
  localparam int unsigned LinW   = 16;
  localparam int unsigned YawW   = 16;
  localparam int unsigned BaseW  = 12;
  localparam int unsigned SpeedW = 19;
  localparam int unsigned AngleW = 15;

  // CORDIC datapath widths: x/y carry 16 fraction bits, z is 1/65536 centidegree
  localparam int unsigned FracW  = 16;
  localparam int unsigned XyW    = 37;
  localparam int unsigned ZW     = 32;
  localparam int unsigned MaxStages = 24;

  // Reset value of the wheel base register, mm
  localparam logic [BaseW-1:0] BaseReset = 12'd500;

  // floor((n + 500) * Recip1000 >> Recip1000Shift) == round(n / 1000) for n < 2^28
  localparam logic [28:0] Recip1000      = 29'd274877907;
  localparam int unsigned Recip1000Shift = 38;
  localparam logic [28:0] HalfThousand   = 29'd500;

  // CORDIC gain correction 0.6072529350 in Q30, rounded away at bit 46
  localparam logic [29:0] GainQ30   = 30'd652032874;
  localparam int unsigned GainShift = 46;

  // Steering angle saturation, centidegrees
  localparam logic [13:0] AngleLimit = 14'd9000;

  // Speed saturation bounds
  localparam logic signed [20:0] SpeedMax = 21'sd262143;
  localparam logic signed [20:0] SpeedMin = -21'sd262144;

  // atan(2^-i) in units of 1/65536 centidegree
  localparam logic [29:0] AtanTab [MaxStages] = '{
    30'd294912000, 30'd174096719, 30'd91987925, 30'd46694507, 30'd23437865,
    30'd11730358,  30'd5866610,   30'd2933484,  30'd1466764,  30'd733385,
    30'd366693,    30'd183346,    30'd91673,    30'd45837,    30'd22918,
    30'd11459,     30'd5730,      30'd2865,     30'd1432,     30'd716,
    30'd358,       30'd179,       30'd90,       30'd45
  };

  // Vector state handed from cell to cell
  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
    logic                  rev;   // driving backward, speed gets negated
    logic                  zero;  // null command, force both results to zero
  } cord_t;

endpackage

`default_nettype wire

// ===== design/tsk_front.sv =====
// ----------------------------------------------------------------------------
// tsk_front
// Lateral term yaw * base / 1000, reverse mirroring and CORDIC operand setup.
// ----------------------------------------------------------------------------
`default_nettype none

module tsk_front import tsk_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic signed [LinW-1:0]  lin_i,
  input  wire logic signed [YawW-1:0]  yaw_i,
  input  wire logic [BaseW-1:0]        base_i,
  output logic                         valid_o,
  output cord_t                        cord_o
);

  // Stage 0 registers: raw product
  logic                    v0_q;
  logic signed [28:0]      prod_q;
  logic signed [LinW-1:0]  lin0_q;

  // Stage 1 registers: rounded lateral magnitude
  logic                    v1_q;
  logic [17:0]             lat_mag_q;
  logic                    lat_neg_q;
  logic signed [LinW-1:0]  lin1_q;

  // Stage 2 registers: CORDIC operands
  logic                    v2_q;
  cord_t                   cord_q;

  logic signed [12:0]      base_s;
  logic signed [28:0]      prod_d;
  logic [27:0]             prod_mag;
  logic [28:0]             num;
  logic [57:0]             recip_prod;
  logic                    rev;
  logic signed [16:0]      lin_ext;
  logic signed [16:0]      x0;
  logic signed [18:0]      lat_s;
  logic signed [18:0]      y0;
  cord_t                   cord_d;

  // Multiply yaw rate by wheel base
  assign base_s = $signed({1'b0, base_i});
  assign prod_d = yaw_i * base_s;

  // Divide magnitude by 1000 with rounding, via reciprocal multiply
  assign prod_mag   = prod_q[28] ? 28'(-prod_q) : 28'(prod_q);
  assign num        = {1'b0, prod_mag} + HalfThousand;
  assign recip_prod = num * Recip1000;

  // Mirror both terms in reverse, scale into the CORDIC format
  always_comb begin
    rev     = lin1_q[LinW-1];
    lin_ext = {lin1_q[LinW-1], lin1_q};
    x0      = rev ? -lin_ext : lin_ext;
    lat_s   = lat_neg_q ? -$signed({1'b0, lat_mag_q}) : $signed({1'b0, lat_mag_q});
    y0      = rev ? -lat_s : lat_s;
    cord_d.x    = {{(XyW-FracW-17){x0[16]}}, x0, {FracW{1'b0}}};
    cord_d.y    = {{(XyW-FracW-19){y0[18]}}, y0, {FracW{1'b0}}};
    cord_d.z    = '0;
    cord_d.rev  = rev;
    cord_d.zero = (x0 == 17'sd0) && (y0 == 19'sd0);
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= prod_d;
      lin0_q    <= lin_i;
      lat_mag_q <= recip_prod[Recip1000Shift +: 18];
      lat_neg_q <= prod_q[28];
      lin1_q    <= lin0_q;
      cord_q    <= cord_d;
    end
  end

  assign valid_o = v2_q;
  assign cord_o  = cord_q;

endmodule

`default_nettype wire

// ===== design/tsk_cell.sv =====
// ----------------------------------------------------------------------------
// tsk_cell
// One CORDIC vectoring rotation, registered, handed to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tsk_cell import tsk_pkg::*; #(
  parameter int unsigned Stage = 0
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  valid_i,
  input  wire cord_t cord_i,
  output logic       valid_o,
  output cord_t      cord_o
);

  logic                   valid_q;
  cord_t                  cord_q;
  cord_t                  cord_d;
  logic signed [XyW-1:0]  dx;
  logic signed [XyW-1:0]  dy;
  logic signed [ZW-1:0]   da;

  // Rotate toward the x axis by atan(2^-Stage)
  always_comb begin
    dx     = cord_i.y >>> Stage;
    dy     = cord_i.x >>> Stage;
    da     = $signed({{(ZW-30){1'b0}}, AtanTab[Stage]});
    cord_d = cord_i;
    if (!cord_i.y[XyW-1]) begin
      cord_d.x = cord_i.x + dx;
      cord_d.y = cord_i.y - dy;
      cord_d.z = cord_i.z + da;
    end else begin
      cord_d.x = cord_i.x - dx;
      cord_d.y = cord_i.y + dy;
      cord_d.z = cord_i.z - da;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cord_q <= cord_d;
    end
  end

  assign valid_o = valid_q;
  assign cord_o  = cord_q;

endmodule

`default_nettype wire

// ===== design/tsk_post.sv =====
// ----------------------------------------------------------------------------
// tsk_post
// Gain correction of the magnitude, angle rounding, sign and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tsk_post import tsk_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire cord_t                   cord_i,
  output logic                         valid_o,
  output logic signed [SpeedW-1:0]     speed_o,
  output logic signed [AngleW-1:0]     angle_o
);

  // Stage P1: split gain products and rounded angle magnitude
  logic                 v1_q;
  logic [47:0]          ph_q;
  logic [47:0]          pl_q;
  logic [13:0]          ang_q;
  logic                 zneg_q;
  logic                 rev_q;
  logic                 zero_q;

  // Stage P2: final results
  logic                       v2_q;
  logic signed [SpeedW-1:0]   speed_q;
  logic signed [AngleW-1:0]   angle_q;

  logic [XyW-2:0]       xc;
  logic [ZW-1:0]        az;
  logic [ZW:0]          az_rnd;
  logic [15:0]          ang_mag;
  logic [13:0]          ang_d;
  logic [65:0]          sum;
  logic [19:0]          spd;
  logic signed [20:0]   spd_s;
  logic signed [SpeedW-1:0] speed_d;
  logic signed [AngleW-1:0] angle_d;

  // Clamp x at zero, round |z| to centidegrees and limit it
  always_comb begin
    xc      = cord_i.x[XyW-1] ? '0 : cord_i.x[XyW-2:0];
    az      = cord_i.z[ZW-1] ? ZW'(-cord_i.z) : ZW'(cord_i.z);
    az_rnd  = {1'b0, az} + (ZW+1)'(32768);
    ang_mag = az_rnd[FracW +: 16];
    ang_d   = (ang_mag > {2'b00, AngleLimit}) ? AngleLimit : ang_mag[13:0];
  end

  // Recombine the gain products, apply direction and saturate
  always_comb begin
    sum   = {ph_q, 18'b0} + {18'b0, pl_q} + (66'd1 << 45);
    spd   = sum[GainShift +: 20];
    spd_s = rev_q ? -$signed({1'b0, spd}) : $signed({1'b0, spd});
    if (spd_s > SpeedMax) begin
      speed_d = SpeedMax[SpeedW-1:0];
    end else if (spd_s < SpeedMin) begin
      speed_d = SpeedMin[SpeedW-1:0];
    end else begin
      speed_d = spd_s[SpeedW-1:0];
    end
    angle_d = zneg_q ? -$signed({1'b0, ang_q}) : $signed({1'b0, ang_q});
    if (zero_q) begin
      speed_d = '0;
      angle_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q    <= xc[XyW-2:18] * GainQ30;
      pl_q    <= xc[17:0] * GainQ30;
      ang_q   <= ang_d;
      zneg_q  <= cord_i.z[ZW-1];
      rev_q   <= cord_i.rev;
      zero_q  <= cord_i.zero;
      speed_q <= speed_d;
      angle_q <= angle_d;
    end
  end

  assign valid_o = v2_q;
  assign speed_o = speed_q;
  assign angle_o = angle_q;

endmodule

`default_nettype wire

// ===== design/tricycle_steer_kinematics.sv =====
// ----------------------------------------------------------------------------
// tricycle_steer_kinematics
// Steered wheel speed and angle of a tricycle from a body speed/yaw command.
// ----------------------------------------------------------------------------
// Takes one command per cycle while the skid entry is free and returns one
// result per command, in order. The lateral term is registered after the
// multiply, the reciprocal divide by 1000 and the mirroring; each CORDIC cell
// in the rotation chain has its own register; gain correction and saturation
// are registered in stages P1 and P2, followed by the output register.
// A two-entry output (result register plus skid register) lets the pipeline
// keep taking commands while a result waits; the input stalls only once the
// skid entry is occupied. The wheel base register may be written only while
// no command is in flight.
`default_nettype none

module tricycle_steer_kinematics import tsk_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // config: wheel_base_mm
  input  wire logic               cfg_we_i,
  input  wire logic [BaseW-1:0]   cfg_wdata_i,
  // command stream
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [31:0]        s_axis_tdata_i,  // [15:0] linear_speed, [31:16] yaw_rate
  // result stream
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic [39:0]             m_axis_tdata_o   // [18:0] wheel_speed, [33:19] steer_angle
);

  localparam int unsigned NumCells = (CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES;

  logic [BaseW-1:0]          base_q;
  logic                      en;
  logic                      link_valid [NumCells+1];
  cord_t                     link_cord  [NumCells+1];
  logic                      res_valid;
  logic signed [SpeedW-1:0]  res_speed;
  logic signed [AngleW-1:0]  res_angle;
  logic                      out_free;
  logic                      out_valid_q;
  logic [33:0]               out_data_q;
  logic                      skid_valid_q;
  logic [33:0]               skid_data_q;

  // Wheel base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // Pipeline advances whenever the skid entry is free
  assign en              = ~skid_valid_q;
  assign s_axis_tready_o = en;

  tsk_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .lin_i   ($signed(s_axis_tdata_i[15:0])),
    .yaw_i   ($signed(s_axis_tdata_i[31:16])),
    .base_i  (base_q),
    .valid_o (link_valid[0]),
    .cord_o  (link_cord[0])
  );

  // Chain of CORDIC cells
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    tsk_cell #(
      .Stage (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (link_valid[g]),
      .cord_i  (link_cord[g]),
      .valid_o (link_valid[g+1]),
      .cord_o  (link_cord[g+1])
    );
  end

  tsk_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (link_valid[NumCells]),
    .cord_i  (link_cord[NumCells]),
    .valid_o (res_valid),
    .speed_o (res_speed),
    .angle_o (res_angle)
  );

  // Output register and skid entry
  assign out_free = ~out_valid_q | m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_data_q <= skid_data_q;
      end
    end else if (out_free) begin
      out_data_q <= {res_angle, res_speed};
    end else begin
      skid_data_q <= {res_angle, res_speed};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_data_q};

  // A parked result always sits behind a pending one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry occupied while output register is empty");

  // A result that meets a stalled output is parked, not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && res_valid && out_valid_q && !m_axis_tready_i) |=> skid_valid_q)
    else $error("result lost on output stall");

  // Steering angle stays within +-90 degrees
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[33:19]) <= 15'sd9000 &&
                         $signed(m_axis_tdata_o[33:19]) >= -15'sd9000))
    else $error("steering angle out of range");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the tricycle steering kinematics block. Commands are
// driven in random bursts against a stalling result receiver. Each accepted
// command is run through a bit-exact model of the lateral term, the vectoring
// CORDIC and the gain correction. Every result transaction is compared field
// by field with the oldest prediction. The wheel base register is stepped
// through its extremes and random values between idle phases.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import tsk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Stages    = 16;
  localparam int unsigned Latency   = 5 + Stages;
  localparam int unsigned Phases    = 7;
  localparam int unsigned PerPhase  = 208;
  localparam int unsigned LongHold  = 400;

  typedef struct {
    logic signed [SpeedW-1:0] speed;
    logic signed [AngleW-1:0] angle;
  } wheel_res_t;

  // Predicts steered wheel speed and angle, and holds them until they arrive
  class wheel_cmd_board;
    wheel_res_t       due_q[$];
    logic [BaseW-1:0] base_mm;
    int unsigned      mismatches;

    function new();
      base_mm    = 12'd500;
      mismatches = 0;
    endfunction

    function void set_base(logic [BaseW-1:0] v);
      base_mm = v;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    // Divide rounding half away from zero
    static function longint round_div(longint num, longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + den / 2) / den;
      return (num < 0) ? -mag : mag;
    endfunction

    // atan(2^-i) in 1/65536 centidegree
    static function longint atan_step(int i);
      case (i)
        0:  return 294912000;
        1:  return 174096719;
        2:  return 91987925;
        3:  return 46694507;
        4:  return 23437865;
        5:  return 11730358;
        6:  return 5866610;
        7:  return 2933484;
        8:  return 1466764;
        9:  return 733385;
        10: return 366693;
        11: return 183346;
        12: return 91673;
        13: return 45837;
        14: return 22918;
        15: return 11459;
        16: return 5730;
        17: return 2865;
        18: return 1432;
        19: return 716;
        20: return 358;
        21: return 179;
        22: return 90;
        default: return 45;
      endcase
    endfunction

    function wheel_res_t predict(logic signed [LinW-1:0] lin, logic signed [YawW-1:0] yaw);
      longint lin_l, lat, x, y, z, dx, dy, spd, ang;
      longint unsigned mag;
      bit rev;
      wheel_res_t r;
      lin_l = lin;
      lat   = round_div(longint'(yaw) * longint'(base_mm), 1000);
      rev   = lin_l < 0;
      x     = rev ? -lin_l : lin_l;
      y     = rev ? -lat : lat;
      z     = 0;
      spd   = 0;
      ang   = 0;
      if (x != 0 || y != 0) begin
        x = x * 65536;
        y = y * 65536;
        // Rotate toward the x axis, accumulating the angle
        for (int i = 0; i < Stages && i < 24; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + atan_step(i);
          end else begin
            x = x - dx;
            y = y + dy;
            z = z - atan_step(i);
          end
        end
        if (x < 0) x = 0;
        // Remove the CORDIC gain, Q30 with rounding at bit 46
        mag = x;
        mag = mag * 64'd652032874 + (64'd1 << 45);
        spd = longint'(mag >> 46);
        ang = round_div(z, 65536);
      end
      if (ang > 9000)  ang = 9000;
      if (ang < -9000) ang = -9000;
      if (rev) spd = -spd;
      if (spd > 262143)  spd = 262143;
      if (spd < -262144) spd = -262144;
      r.speed = spd[SpeedW-1:0];
      r.angle = ang[AngleW-1:0];
      return r;
    endfunction

    function void note_command(logic [31:0] data);
      due_q.push_back(predict(data[15:0], data[31:16]));
    endfunction

    function void check_result(logic [39:0] data);
      wheel_res_t got, want;
      logic [5:0] pad;
      got.speed = data[18:0];
      got.angle = data[33:19];
      pad       = data[39:34];
      if (due_q.size() == 0) begin
        $error("result with no command outstanding: wheel_speed %0d steer_angle %0d",
               got.speed, got.angle);
        mismatches++;
        return;
      end
      want = due_q.pop_front();
      if (got.speed !== want.speed) begin
        $error("wheel_speed: expected %0d, got %0d", want.speed, got.speed);
        mismatches++;
      end
      if (got.angle !== want.angle) begin
        $error("steer_angle: expected %0d, got %0d", want.angle, got.angle);
        mismatches++;
      end
      if (pad !== 6'd0) begin
        $error("tdata pad: expected 0, got %0h", pad);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni         = 1'b0;
  logic             cfg_we         = 1'b0;
  logic [BaseW-1:0] cfg_wdata      = '0;
  logic             s_axis_tvalid  = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata   = '0;    // [15:0] linear_speed, [31:16] yaw_rate
  logic             m_axis_tvalid;
  logic             m_axis_tready  = 1'b0;
  logic [39:0]      m_axis_tdata;           // [18:0] wheel_speed, [33:19] steer_angle

  wheel_cmd_board board = new();
  bit             hold_req = 1'b0;
  int unsigned    burst_left = 0;

  tricycle_steer_kinematics #(
    .CORDIC_STAGES(Stages)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop for a hung run
  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end

  // Compare every result transaction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // Drive result backpressure: random segments of patterns, plus one long hold
  initial begin : result_sink
    int unsigned seg_left, mode, tick;
    seg_left = 0;
    mode     = 0;
    tick     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 4);
          seg_left = $urandom_range(16, 128);
        end
        seg_left--;
        tick++;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= $urandom_range(0, 1);
          2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
          3:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (tick % 5) != 0;
        endcase
      end
    end
  end

  // Offer one command and hold it until accepted
  task automatic send_cmd(input logic signed [15:0] lin, input logic signed [15:0] yaw);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {yaw, lin};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    board.note_command({yaw, lin});
  endtask

  // Idle the command side with noise on tdata
  task automatic idle_input(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
    end
  endtask

  // Send in bursts of random length separated by random gaps
  task automatic offer(input logic signed [15:0] lin, input logic signed [15:0] yaw);
    if (burst_left == 0) begin
      idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    send_cmd(lin, yaw);
  endtask

  // Wait until every predicted result has arrived, then let the pipe settle
  task automatic drain();
    idle_input(1);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [BaseW-1:0] v);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    board.set_base(v);
  endtask

  // Mix of full-range, small, extreme and near-axis commands
  task automatic random_cmd(output logic signed [15:0] lin, output logic signed [15:0] yaw);
    logic [15:0] ext [4];
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    lin = $urandom;
    yaw = $urandom;
    case ($urandom_range(0, 9))
      4, 5: begin
        lin = $signed($urandom_range(0, 400)) - 200;
        yaw = $signed($urandom_range(0, 400)) - 200;
      end
      6: begin
        lin = ext[$urandom_range(0, 3)];
        yaw = ext[$urandom_range(0, 3)];
      end
      7: begin
        if ($urandom_range(0, 1)) lin = 0;
        else yaw = 0;
      end
      8: lin = $signed($urandom_range(0, 8)) - 4;
      9: begin
        lin = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
        yaw = $signed($urandom_range(0, 6)) - 3;
      end
      default: ;
    endcase
  endtask

  // Field extremes, straight and pure-turn commands, reverse and rounding edges
  task automatic run_directed();
    offer(16'sd0, 16'sd0);
    offer(16'sd32767, 16'sd0);
    offer(-16'sd32768, 16'sd0);
    offer(16'sd0, 16'sd32767);
    offer(16'sd0, -16'sd32768);
    offer(16'sd32767, 16'sd32767);
    offer(16'sd32767, -16'sd32768);
    offer(-16'sd32768, 16'sd32767);
    offer(-16'sd32768, -16'sd32768);
    offer(-16'sd1, 16'sd0);
    offer(16'sd1, 16'sd0);
    offer(16'sd0, 16'sd1);
    offer(16'sd0, -16'sd1);
    offer(-16'sd1, -16'sd1);
    offer(16'sd100, 16'sd1000);
    offer(-16'sd100, 16'sd1000);
    offer(16'sd1000, -16'sd5);
    offer(-16'sd1000, -16'sd5);
    offer(16'sd5, 16'sd1);
    offer(-16'sd1, 16'sd1);
    offer(16'sd3, -16'sd32768);
  endtask

  initial begin : stimulus
    logic signed [15:0] lin, yaw;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < Phases; phase++) begin
      // Step the wheel base: reset value, maximum, one, zero, then random
      case (phase)
        0:       ;
        1:       write_base(12'd4095);
        2:       write_base(12'd1);
        3:       write_base(12'd0);
        default: write_base($urandom_range(2, 4094));
      endcase
      run_directed();
      for (int k = 0; k < PerPhase; k++) begin
        if (phase == 1 && k == 60) hold_req = 1'b1;
        if (phase == 2 && k == 100) drain();
        random_cmd(lin, yaw);
        offer(lin, yaw);
      end
      drain();
    end

    if (board.mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
